// ===== src/decoder_config_record_nal_extractor_core_assert.svh =====
// Assertion helpers used by the extractor core.
`ifndef DECODER_CONFIG_RECORD_NAL_EXTRACTOR_CORE_ASSERT_SVH
`define DECODER_CONFIG_RECORD_NAL_EXTRACTOR_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DCRNE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dcrne same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define DCRNE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dcrne next-cycle check failed");

`endif

// ===== src/dcrne_pkg.sv =====
package dcrne_pkg;

	typedef enum logic [3:0] {
		PH_HEADER        = 4'd0,
		PH_AVC_SPS_COUNT = 4'd1,
		PH_AVC_PPS_COUNT = 4'd2,
		PH_HEVC_ARRAYS   = 4'd3,
		PH_HEVC_TYPE     = 4'd4,
		PH_HEVC_NUM_HI   = 4'd5,
		PH_HEVC_NUM_LO   = 4'd6,
		PH_LEN_HI        = 4'd7,
		PH_LEN_LO        = 4'd8,
		PH_PAYLOAD       = 4'd9,
		PH_COMPLETE      = 4'd10
	} phase_t;

	localparam logic [1:0] KIND_VPS = 2'd0;
	localparam logic [1:0] KIND_SPS = 2'd1;
	localparam logic [1:0] KIND_PPS = 2'd2;

	localparam logic [1:0] CFG_RECORD_MODE = 2'd0;
	localparam logic [1:0] CFG_VPS_TYPE    = 2'd1;
	localparam logic [1:0] CFG_SPS_TYPE    = 2'd2;
	localparam logic [1:0] CFG_PPS_TYPE    = 2'd3;

	localparam logic [5:0] AVC_HDR_LEN     = 6'd5;
	localparam logic [5:0] HEVC_HDR_LEN    = 6'd22;
	localparam logic [7:0] AVC_IGNORE_MASK = 8'hE0;
	localparam logic [7:0] HEVC_TYPE_MASK  = 8'h3F;

	localparam logic [5:0] VPS_TYPE_RST = 6'd32;
	localparam logic [5:0] SPS_TYPE_RST = 6'd33;
	localparam logic [5:0] PPS_TYPE_RST = 6'd34;

	typedef struct packed {
		logic       hevc;
		logic [5:0] vps_type;
		logic [5:0] sps_type;
		logic [5:0] pps_type;
	} cfg_t;

	typedef struct packed {
		phase_t      phase;
		logic [4:0]  skip;
		logic [7:0]  groups;
		logic [15:0] units;
		logic [15:0] bytes;
		logic [7:0]  hold;
		logic [1:0]  kind;
		logic        kept;
		logic        hevc;
	} state_t;

	typedef struct packed {
		logic        fire;
		logic        unit_begin;
		logic [1:0]  unit_kind;
		logic [15:0] unit_length;
		logic        byte_valid;
		logic [7:0]  payload_byte;
		logic        unit_end;
		logic        record_done;
		logic        parse_status;
	} result_t;

endpackage

// ===== src/dcrne_step.sv =====
module dcrne_step (
	input  dcrne_pkg::state_t  st,
	input  dcrne_pkg::cfg_t    cfg,
	input  logic [7:0]         in_byte,
	input  logic               record_end,
	output dcrne_pkg::state_t  nxt,
	output dcrne_pkg::result_t res
);

	logic [5:0]  hdr_cnt;
	logic [5:0]  hdr_len;
	logic [15:0] count;
	logic [15:0] unit_dec;
	logic [15:0] byte_dec;
	logic [15:0] len_full;
	logic [5:0]  nal_type;
	dcrne_pkg::state_t parsed;

	// Phase after the last unit of a list or array.
	function automatic dcrne_pkg::phase_t group_next(input logic hevc, input logic [7:0] groups,
			input logic [1:0] kind);
		if (hevc)
			return (groups != 8'd0) ? dcrne_pkg::PH_HEVC_TYPE : dcrne_pkg::PH_COMPLETE;
		else
			return (kind == dcrne_pkg::KIND_SPS) ? dcrne_pkg::PH_AVC_PPS_COUNT
				: dcrne_pkg::PH_COMPLETE;
	endfunction

	assign hdr_cnt  = {1'b0, st.skip} + 6'd1;
	assign hdr_len  = cfg.hevc ? dcrne_pkg::HEVC_HDR_LEN : dcrne_pkg::AVC_HDR_LEN;
	assign unit_dec = st.units - 16'd1;
	assign byte_dec = st.bytes - 16'd1;
	assign len_full = {st.hold, in_byte};
	assign nal_type = in_byte[5:0] & dcrne_pkg::HEVC_TYPE_MASK[5:0];

	// Next state of the parser for this byte.
	always_comb begin
		parsed = st;
		count  = 16'd0;
		unique case (st.phase)
			dcrne_pkg::PH_HEADER: begin
				if (hdr_cnt >= hdr_len) begin
					parsed.hevc  = cfg.hevc;
					parsed.phase = cfg.hevc ? dcrne_pkg::PH_HEVC_ARRAYS
						: dcrne_pkg::PH_AVC_SPS_COUNT;
					parsed.skip  = 5'd0;
				end else begin
					parsed.skip = hdr_cnt[4:0];
				end
			end
			dcrne_pkg::PH_AVC_SPS_COUNT, dcrne_pkg::PH_AVC_PPS_COUNT: begin
				parsed.kept = 1'b1;
				if (st.phase == dcrne_pkg::PH_AVC_SPS_COUNT) begin
					parsed.kind = dcrne_pkg::KIND_SPS;
					count = {8'd0, in_byte & ~dcrne_pkg::AVC_IGNORE_MASK};
				end else begin
					parsed.kind = dcrne_pkg::KIND_PPS;
					count = {8'd0, in_byte};
				end
				parsed.units = count;
				parsed.phase = (count != 16'd0) ? dcrne_pkg::PH_LEN_HI
					: group_next(parsed.hevc, parsed.groups, parsed.kind);
			end
			dcrne_pkg::PH_HEVC_ARRAYS: begin
				parsed.groups = in_byte;
				parsed.phase  = (in_byte != 8'd0) ? dcrne_pkg::PH_HEVC_TYPE
					: dcrne_pkg::PH_COMPLETE;
			end
			dcrne_pkg::PH_HEVC_TYPE: begin
				parsed.groups = st.groups - 8'd1;
				parsed.kept   = 1'b1;
				// VPS code wins over SPS, SPS over PPS.
				priority if (nal_type == cfg.vps_type)
					parsed.kind = dcrne_pkg::KIND_VPS;
				else if (nal_type == cfg.sps_type)
					parsed.kind = dcrne_pkg::KIND_SPS;
				else if (nal_type == cfg.pps_type)
					parsed.kind = dcrne_pkg::KIND_PPS;
				else begin
					parsed.kind = dcrne_pkg::KIND_VPS;
					parsed.kept = 1'b0;
				end
				parsed.phase = dcrne_pkg::PH_HEVC_NUM_HI;
			end
			dcrne_pkg::PH_HEVC_NUM_HI, dcrne_pkg::PH_LEN_HI: begin
				parsed.hold  = in_byte;
				parsed.phase = (st.phase == dcrne_pkg::PH_LEN_HI) ? dcrne_pkg::PH_LEN_LO
					: dcrne_pkg::PH_HEVC_NUM_LO;
			end
			dcrne_pkg::PH_HEVC_NUM_LO: begin
				parsed.units = len_full;
				parsed.phase = (len_full != 16'd0) ? dcrne_pkg::PH_LEN_HI
					: group_next(st.hevc, st.groups, st.kind);
			end
			dcrne_pkg::PH_LEN_LO: begin
				parsed.bytes = len_full;
				if (len_full != 16'd0)
					parsed.phase = dcrne_pkg::PH_PAYLOAD;
				else begin
					parsed.units = unit_dec;
					parsed.phase = (unit_dec != 16'd0) ? dcrne_pkg::PH_LEN_HI
						: group_next(st.hevc, st.groups, st.kind);
				end
			end
			dcrne_pkg::PH_PAYLOAD: begin
				parsed.bytes = byte_dec;
				if (byte_dec == 16'd0) begin
					parsed.units = unit_dec;
					parsed.phase = (unit_dec != 16'd0) ? dcrne_pkg::PH_LEN_HI
						: group_next(st.hevc, st.groups, st.kind);
				end
			end
			default: parsed.phase = dcrne_pkg::PH_COMPLETE;
		endcase
	end

	// Restart at the header after the closing byte.
	always_comb begin
		if (record_end) begin
			nxt       = '0;
			nxt.phase = dcrne_pkg::PH_HEADER;
		end else begin
			nxt = parsed;
		end
	end

	// Result of this byte.
	always_comb begin
		res = '0;
		if (st.kept && st.phase == dcrne_pkg::PH_LEN_LO) begin
			res.unit_begin  = 1'b1;
			res.unit_kind   = st.kind;
			res.unit_length = len_full;
		end
		if (st.kept && st.phase == dcrne_pkg::PH_PAYLOAD) begin
			res.byte_valid   = 1'b1;
			res.unit_kind    = st.kind;
			res.payload_byte = in_byte;
			res.unit_end     = (byte_dec == 16'd0);
		end
		if (record_end) begin
			res.record_done  = 1'b1;
			res.parse_status = (parsed.phase != dcrne_pkg::PH_COMPLETE);
		end
		res.fire = res.unit_begin | res.byte_valid | res.record_done;
	end

endmodule

// ===== src/decoder_config_record_nal_extractor_core.sv =====
// Parameter-set extractor for avcC / hvcC decoder configuration records.
// Input channel (in_valid/in_ready): one record byte per beat, record_end
// marks the final byte of a record. Output channel (out_valid/out_ready):
// a beat announces a kept VPS/SPS/PPS unit (unit_begin, unit_kind,
// unit_length, given on the second length byte), carries one payload byte
// (byte_valid, payload_byte, unit_end on the last one), and/or closes the
// record (record_done with parse_status 0 complete, 1 truncated). Bytes
// that produce nothing (header, counts, skipped units) give no beat.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 mode
// (0 AVC, 1 HEVC), 1..3 VPS/SPS/PPS NAL type codes; always ready. Write
// only while the block is idle.
// The output register loads a beat's result at the edge that accepts the
// beat. Throughput: one byte per cycle unless stalled; the whole parse step
// is one combinational pass between the state and output registers.
// Stall: in_ready drops only while a result is held and out_ready is low.
// Reset: mode AVC, type codes 32/33/34, parser at header skip, no result.
module decoder_config_record_nal_extractor_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        record_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        unit_begin,
	output logic [1:0]  unit_kind,
	output logic [15:0] unit_length,
	output logic        byte_valid,
	output logic [7:0]  payload_byte,
	output logic        unit_end,
	output logic        record_done,
	output logic        parse_status
);

`include "decoder_config_record_nal_extractor_core_assert.svh"

	dcrne_pkg::cfg_t    cfg_q;
	dcrne_pkg::state_t  st_q;
	dcrne_pkg::state_t  st_nxt;
	dcrne_pkg::result_t res_nxt;
	dcrne_pkg::result_t res_q;
	logic               out_valid_q;
	logic               in_fire;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hevc     <= 1'b0;
			cfg_q.vps_type <= dcrne_pkg::VPS_TYPE_RST;
			cfg_q.sps_type <= dcrne_pkg::SPS_TYPE_RST;
			cfg_q.pps_type <= dcrne_pkg::PPS_TYPE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				dcrne_pkg::CFG_RECORD_MODE: cfg_q.hevc     <= cfg_data[0];
				dcrne_pkg::CFG_VPS_TYPE:    cfg_q.vps_type <= cfg_data[5:0];
				dcrne_pkg::CFG_SPS_TYPE:    cfg_q.sps_type <= cfg_data[5:0];
				dcrne_pkg::CFG_PPS_TYPE:    cfg_q.pps_type <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	dcrne_step u_step (
		.st         (st_q),
		.cfg        (cfg_q),
		.in_byte    (in_byte),
		.record_end (record_end),
		.nxt        (st_nxt),
		.res        (res_nxt)
	);

	// Advance the parser on every accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			// The all-zero state is the header skip phase.
			st_q <= '0;
		end else if (in_fire) begin
			st_q <= st_nxt;
		end
	end

	// Output register: load a new result, or drop the held one once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (in_fire)
			out_valid_q <= res_nxt.fire;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_fire && res_nxt.fire)
			res_q <= res_nxt;
	end

	assign out_valid    = out_valid_q;
	assign unit_begin   = res_q.unit_begin;
	assign unit_kind    = res_q.unit_kind;
	assign unit_length  = res_q.unit_length;
	assign byte_valid   = res_q.byte_valid;
	assign payload_byte = res_q.payload_byte;
	assign unit_end     = res_q.unit_end;
	assign record_done  = res_q.record_done;
	assign parse_status = res_q.parse_status;

	// A held beat always carries an announcement, a byte or a close.
	`DCRNE_ASSERT_NOW(a_beat_has_content, clk, arst_n, out_valid_q,
		res_q.unit_begin || res_q.byte_valid || res_q.record_done)
	// Announcement and payload byte never share a beat.
	`DCRNE_ASSERT_NOW(a_begin_xor_byte, clk, arst_n, out_valid_q,
		!(res_q.unit_begin && res_q.byte_valid))
	// unit_end only rides on a payload byte.
	`DCRNE_ASSERT_NOW(a_end_on_byte, clk, arst_n, out_valid_q && res_q.unit_end,
		res_q.byte_valid)
	// Closing byte returns the parser to header skip.
	`DCRNE_ASSERT_NEXT(a_restart, clk, arst_n, in_fire && record_end,
		st_q.phase == dcrne_pkg::PH_HEADER && st_q.skip == 5'd0)

endmodule
